>>> hdl/pfe_pkg.sv
`timescale 1ns / 1ps

package pfe_pkg;

   // key square geometry
   localparam int SqSide = 5;

   // letter indexes, 0 for A
   localparam logic [4:0] LetterI    = 5'd8;
   localparam logic [4:0] LetterJ    = 5'd9;
   localparam logic [4:0] LetterX    = 5'd23;
   localparam logic [4:0] LastLetter = 5'd25;

   localparam logic [7:0] AsciiUpperA = 8'h41;
   localparam logic [7:0] AsciiUpperZ = 8'h5A;
   localparam logic [7:0] AsciiLowerA = 8'h61;
   localparam logic [7:0] AsciiLowerZ = 8'h7A;

   localparam int QueueDepthDefault = 2;

   typedef enum logic [1:0] {
      CMD_KEY_CHAR   = 2'd0,
      CMD_KEY_END    = 2'd1,
      CMD_PLAIN_CHAR = 2'd2,
      CMD_MSG_END    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_KEY_LETTER,
      OP_KEY_END,
      OP_PLAIN_LETTER,
      OP_MSG_END
   } op_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] character;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] cipher_letter;
      logic       last;
   } rsp_payload_type;

   // one classified request between front and back
   typedef struct packed {
      op_type     op;
      logic [4:0] letter;
   } entry_type;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } pos_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_FILL,
      BK_POS,
      BK_EMIT0,
      BK_EMIT1
   } back_state_type;

   // cell number row*5+col, row and col below 5
   function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
      cell_addr = {row[2:0], 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   function automatic logic [2:0] inc_wrap(input logic [2:0] v);
      inc_wrap = (v == 3'(SqSide - 1)) ? 3'd0 : v + 3'd1;
   endfunction

endpackage

>>> hdl/pfe_front.sv
`timescale 1ns / 1ps

module pfe_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pfe_pkg::req_payload_type req_payload,
   input  logic                     q_ready,
   output logic                     push,
   output pfe_pkg::entry_type       push_entry
);

   logic       is_upper;
   logic       is_lower;
   logic       is_letter;
   logic [7:0] offset;
   logic [4:0] letter;
   logic       drop;

   always_comb begin
      is_upper  = (req_payload.character >= pfe_pkg::AsciiUpperA) &&
                  (req_payload.character <= pfe_pkg::AsciiUpperZ);
      is_lower  = (req_payload.character >= pfe_pkg::AsciiLowerA) &&
                  (req_payload.character <= pfe_pkg::AsciiLowerZ);
      is_letter = is_upper || is_lower;
      offset    = is_lower ? req_payload.character - pfe_pkg::AsciiLowerA
                           : req_payload.character - pfe_pkg::AsciiUpperA;
      letter    = offset[4:0];
      if (letter == pfe_pkg::LetterJ) begin
         letter = pfe_pkg::LetterI;
      end

      drop = 1'b0;
      push_entry.letter = letter;
      case (pfe_pkg::cmd_type'(req_payload.command))
         pfe_pkg::CMD_KEY_CHAR: begin
            push_entry.op = pfe_pkg::OP_KEY_LETTER;
            drop = !is_letter;
         end
         pfe_pkg::CMD_KEY_END: begin
            push_entry.op = pfe_pkg::OP_KEY_END;
         end
         pfe_pkg::CMD_PLAIN_CHAR: begin
            push_entry.op = pfe_pkg::OP_PLAIN_LETTER;
            drop = !is_letter;
         end
         default: begin
            push_entry.op = pfe_pkg::OP_MSG_END;
         end
      endcase
   end

   // non-letters are taken and forgotten here
   assign req_ready = q_ready;
   assign push      = req_valid && q_ready && !drop;

endmodule

>>> hdl/pfe_fifo.sv
`timescale 1ns / 1ps

module pfe_fifo #(
   parameter int Depth = pfe_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pfe_pkg::entry_type push_entry,
   output logic               q_ready,
   output logic               head_valid,
   output pfe_pkg::entry_type head_entry,
   input  logic               pop
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   pfe_pkg::entry_type slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign q_ready    = (count_ff != CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && q_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/pfe_back.sv
`timescale 1ns / 1ps

module pfe_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  pfe_pkg::entry_type       head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pfe_pkg::rsp_payload_type rsp_payload
);

   pfe_pkg::back_state_type state_ff, state_in;

   // key square and letter positions, no reset: read only once the square is full
   logic [4:0]       key_sq_ff  [25];
   pfe_pkg::pos_type let_pos_ff [26];

   logic [25:0]      used_ff, used_in;
   logic [2:0]       fill_row_ff, fill_row_in;
   logic [2:0]       fill_col_ff, fill_col_in;
   logic             key_ready_ff, key_ready_in;
   logic [4:0]       pend_letter_ff, pend_letter_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [4:0]       walk_ff, walk_in;
   pfe_pkg::pos_type pos1_ff, pos2_ff;
   logic [4:0]       cell1_ff, cell2_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   pfe_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic             place_req;
   logic [4:0]       place_letter;
   logic             place_en;
   logic             square_full;
   logic             pos_load;
   logic [4:0]       rd_b;
   logic             out_free;
   logic [2:0]       q1_row, q1_col, q2_row, q2_col;

   assign square_full = (fill_row_ff == 3'(pfe_pkg::SqSide));
   assign place_en    = place_req && !used_ff[place_letter] && !square_full;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // enciphering rules on the registered positions
   always_comb begin
      if (pos1_ff.row == pos2_ff.row) begin
         q1_row = pos1_ff.row;
         q1_col = pfe_pkg::inc_wrap(pos1_ff.col);
         q2_row = pos2_ff.row;
         q2_col = pfe_pkg::inc_wrap(pos2_ff.col);
      end else if (pos1_ff.col == pos2_ff.col) begin
         q1_row = pfe_pkg::inc_wrap(pos1_ff.row);
         q1_col = pos1_ff.col;
         q2_row = pfe_pkg::inc_wrap(pos2_ff.row);
         q2_col = pos2_ff.col;
      end else begin
         q1_row = pos1_ff.row;
         q1_col = pos2_ff.col;
         q2_row = pos2_ff.row;
         q2_col = pos1_ff.col;
      end
   end

   always_comb begin
      state_in       = state_ff;
      pop            = 1'b0;
      place_req      = 1'b0;
      place_letter   = head_entry.letter;
      pos_load       = 1'b0;
      rd_b           = pfe_pkg::LetterX;
      key_ready_in   = key_ready_ff;
      pend_letter_in = pend_letter_ff;
      pend_valid_in  = pend_valid_ff;
      walk_in        = walk_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      case (state_ff)
         pfe_pkg::BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               case (head_entry.op)
                  pfe_pkg::OP_KEY_LETTER: begin
                     place_req = !key_ready_ff;
                  end
                  pfe_pkg::OP_KEY_END: begin
                     if (!key_ready_ff) begin
                        walk_in  = '0;
                        state_in = pfe_pkg::BK_FILL;
                     end
                  end
                  pfe_pkg::OP_PLAIN_LETTER: begin
                     if (key_ready_ff) begin
                        if (!pend_valid_ff) begin
                           pend_letter_in = head_entry.letter;
                           pend_valid_in  = 1'b1;
                        end else begin
                           // a doubled letter is closed by the filler and stays open
                           if (head_entry.letter != pend_letter_ff) begin
                              rd_b          = head_entry.letter;
                              pend_valid_in = 1'b0;
                           end
                           pos_load = 1'b1;
                           state_in = pfe_pkg::BK_POS;
                        end
                     end
                  end
                  default: begin
                     pend_valid_in = 1'b0;
                     if (key_ready_ff && pend_valid_ff) begin
                        pos_load = 1'b1;
                        state_in = pfe_pkg::BK_POS;
                     end
                  end
               endcase
            end
         end
         pfe_pkg::BK_FILL: begin
            place_req    = (walk_ff != pfe_pkg::LetterJ);
            place_letter = walk_ff;
            if (walk_ff == pfe_pkg::LastLetter) begin
               key_ready_in = 1'b1;
               state_in     = pfe_pkg::BK_IDLE;
            end else begin
               walk_in = walk_ff + 5'd1;
            end
         end
         pfe_pkg::BK_POS: begin
            state_in = pfe_pkg::BK_EMIT0;
         end
         pfe_pkg::BK_EMIT0: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.cipher_letter = 7'(pfe_pkg::AsciiUpperA) + {2'b00, cell1_ff};
               rsp_payload_in.last          = 1'b0;
               state_in                     = pfe_pkg::BK_EMIT1;
            end
         end
         pfe_pkg::BK_EMIT1: begin
            if (out_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.cipher_letter = 7'(pfe_pkg::AsciiUpperA) + {2'b00, cell2_ff};
               rsp_payload_in.last          = 1'b1;
               state_in                     = pfe_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pfe_pkg::BK_IDLE;
         end
      endcase

      used_in     = used_ff;
      fill_row_in = fill_row_ff;
      fill_col_in = fill_col_ff;
      if (place_en) begin
         used_in[place_letter] = 1'b1;
         if (fill_col_ff == 3'(pfe_pkg::SqSide - 1)) begin
            fill_col_in = '0;
            fill_row_in = fill_row_ff + 3'd1;
         end else begin
            fill_col_in = fill_col_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfe_pkg::BK_IDLE;
         used_ff       <= '0;
         fill_row_ff   <= '0;
         fill_col_ff   <= '0;
         key_ready_ff  <= 1'b0;
         pend_letter_ff <= '0;
         pend_valid_ff <= 1'b0;
         walk_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         fill_row_ff   <= fill_row_in;
         fill_col_ff   <= fill_col_in;
         key_ready_ff  <= key_ready_in;
         pend_letter_ff <= pend_letter_in;
         pend_valid_ff <= pend_valid_in;
         walk_ff       <= walk_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   // square stores: one write port, two registered read ports each
   always_ff @(posedge clock) begin
      if (place_en) begin
         key_sq_ff[pfe_pkg::cell_addr(fill_row_ff, fill_col_ff)] <= place_letter;
         let_pos_ff[place_letter] <= '{row: fill_row_ff, col: fill_col_ff};
      end
      if (pos_load) begin
         pos1_ff <= let_pos_ff[pend_letter_ff];
         pos2_ff <= let_pos_ff[rd_b];
      end
      if (state_ff == pfe_pkg::BK_POS) begin
         cell1_ff <= key_sq_ff[pfe_pkg::cell_addr(q1_row, q1_col)];
         cell2_ff <= key_sq_ff[pfe_pkg::cell_addr(q2_row, q2_col)];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_used_matches_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(fill_row_ff) * pfe_pkg::SqSide + int'(fill_col_ff))
      else $error("used letters disagree with square fill");

   a_ready_means_full: assert property (@(posedge clock) disable iff (reset)
      key_ready_ff |-> square_full)
      else $error("cipher armed with a partial square");

   a_ready_sticks: assert property (@(posedge clock) disable iff (reset)
      key_ready_ff |=> key_ready_ff)
      else $error("key ready dropped");

   a_pending_needs_key: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> key_ready_ff)
      else $error("open letter before key end");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfe_pkg::BK_FILL && walk_ff == pfe_pkg::LastLetter)
         |=> (state_ff == pfe_pkg::BK_IDLE && key_ready_ff))
      else $error("alphabet walk did not finish");

endmodule

>>> hdl/playfair_cipher_encrypt_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake                payload
// req       in         req_valid / req_ready    req_payload: command, character
// rsp       out        rsp_valid / rsp_ready    rsp_payload: cipher_letter, last
//
// steps: a key character or a plaintext letter opening a pair is just taken; key end is taken,
//   then one alphabet letter a cycle; a digraph: position read, square read, two letters
// the two registered read ports of the square stores set the digraph's read steps
// reset: synchronous; no clearing pass, square stores are read only once full
// stalls: a held result stops the back end at its next emit; requests still enter the queue
//   until it is full, non-letters are taken without entering it
module playfair_cipher_encrypt_top #(
   parameter int QueueDepth = pfe_pkg::QueueDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pfe_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output pfe_pkg::rsp_payload_type rsp_payload
);

   logic               q_ready;
   logic               push;
   pfe_pkg::entry_type push_entry;
   logic               head_valid;
   pfe_pkg::entry_type head_entry;
   logic               pop;

   pfe_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .q_ready    (q_ready),
      .push       (push),
      .push_entry (push_entry)
   );

   pfe_fifo #(
      .Depth(QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .q_ready   (q_ready),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .pop       (pop)
   );

   pfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
